### hw/rtl/spsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo pulse generator package
// Operation codes, field widths, fixed constants and the angle-to-width table.
// ----------------------------------------------------------------------------
package spsg_pkg;

    localparam int unsigned ANGLE_W      = 8;
    localparam int unsigned WIDTH_W      = 9;
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned BASE_W       = 10;

    localparam int unsigned ANGLE_MAX    = 180;
    localparam int unsigned SPAN_TICKS   = 340;
    localparam int unsigned BASE_RESET   = 110;
    localparam int unsigned ANGLE_CODES  = 256;

    typedef enum logic [1:0] {
        OP_FINE_TICK  = 2'd0,
        OP_FRAME_TICK = 2'd1,
        OP_SET_TARGET = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic [ANGLE_W-1:0] target;
    } t_item;

    typedef struct packed {
        logic               level;
        logic [ANGLE_W-1:0] angle;
        logic               running;
    } t_result;

    typedef logic [WIDTH_W-1:0] t_width_table [ANGLE_CODES];

    // Pulse width in fine ticks for every angle code, truncated.
    function automatic t_width_table f_build_width_table();
        t_width_table tbl;
        for (int i = 0; i < ANGLE_CODES; i++) begin
            tbl[i] = WIDTH_W'((i * SPAN_TICKS) / ANGLE_MAX);
        end
        return tbl;
    endfunction

    localparam t_width_table WIDTH_TABLE = f_build_width_table();

endpackage
`default_nettype wire

### hw/rtl/spsg_servo_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo state update
// Holds the slewed angle, target, pulse width and pulse timer, and applies
// one item per cycle when fired. The state registers are the result fields.
// ----------------------------------------------------------------------------
module spsg_servo_state
    import spsg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [BASE_W-1:0] i_cfg_data,
    input  wire logic              i_fire,
    input  wire t_item             i_item,
    output t_result                o_result
);

    logic [BASE_W-1:0]  r_base;
    logic [ANGLE_W-1:0] r_angle_now, n_angle_now;
    logic [ANGLE_W-1:0] r_angle_goal, n_angle_goal;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic [COUNT_W-1:0] r_tick_count, n_tick_count;
    logic               r_pulse_on, n_pulse_on;
    logic               r_level, n_level;

    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] count_inc;

    assign limit     = COUNT_W'(r_base) + COUNT_W'(r_width);
    assign count_inc = r_tick_count + COUNT_W'(1);

    always_comb begin
        n_angle_now  = r_angle_now;
        n_angle_goal = r_angle_goal;
        n_width      = r_width;
        n_tick_count = r_tick_count;
        n_pulse_on   = r_pulse_on;
        n_level      = r_level;
        if (i_fire) begin
            case (t_op'(i_item.op))
                OP_FINE_TICK: begin
                    if (r_pulse_on) begin
                        if (count_inc <= limit) begin
                            n_tick_count = count_inc;
                            n_level      = 1'b1;
                        end else begin
                            // past the high time: drop the line and end the pulse
                            n_tick_count = '0;
                            n_level      = 1'b0;
                            n_pulse_on   = 1'b0;
                        end
                    end
                end
                OP_FRAME_TICK: begin
                    if (r_angle_now > r_angle_goal) begin
                        n_angle_now = r_angle_now - ANGLE_W'(1);
                    end else if (r_angle_now < r_angle_goal) begin
                        n_angle_now = r_angle_now + ANGLE_W'(1);
                    end
                    n_width    = WIDTH_TABLE[n_angle_now];
                    n_pulse_on = 1'b1;
                end
                OP_SET_TARGET: begin
                    n_angle_goal = (i_item.target > ANGLE_W'(ANGLE_MAX)) ?
                                   ANGLE_W'(ANGLE_MAX) : i_item.target;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= BASE_W'(BASE_RESET);
            r_angle_now  <= '0;
            r_angle_goal <= '0;
            r_width      <= '0;
            r_tick_count <= '0;
            r_pulse_on   <= 1'b0;
            r_level      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            r_angle_now  <= n_angle_now;
            r_angle_goal <= n_angle_goal;
            r_width      <= n_width;
            r_tick_count <= n_tick_count;
            r_pulse_on   <= n_pulse_on;
            r_level      <= n_level;
        end
    end

    assign o_result.level   = r_level;
    assign o_result.angle   = r_angle_now;
    assign o_result.running = r_pulse_on;

`ifndef SYNTHESIS
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle_now <= ANGLE_W'(ANGLE_MAX) && r_angle_goal <= ANGLE_W'(ANGLE_MAX))
        else $error("angle beyond limit");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pulse_on |-> (r_tick_count == '0 && !r_level))
        else $error("timer or line active without a pulse");

    a_slew_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_angle_now == $past(r_angle_now) ||
                            r_angle_now == $past(r_angle_now) + ANGLE_W'(1) ||
                            r_angle_now == $past(r_angle_now) - ANGLE_W'(1)))
        else $error("angle moved more than one degree");
`endif

endmodule
`default_nettype wire

### hw/rtl/servo_pulse_generator_slewed_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted item waits in the input register; when it fires, the state
// update writes the state/result registers and sets result valid.
// Throughput: one item per cycle; the input register keeps taking items
// while a result waits, and stalls only when both stages are full.
// Reset: synchronous active low; clears the valid flags and servo state, base ticks return to 110.
// ----------------------------------------------------------------------------
// Slew-limited servo pulse generator
// Input register, state update stage and output handshake.
// ----------------------------------------------------------------------------
module servo_pulse_generator_slewed_core
    import spsg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [BASE_W-1:0]  i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic [ANGLE_W-1:0] i_target_angle,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_servo_level,
    output logic [ANGLE_W-1:0]      o_current_angle,
    output logic                    o_pulse_running
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    logic    out_free;
    logic    fire;
    logic    in_take;
    t_result result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload needs no reset; hold it until the next item is taken.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.op     <= i_operation;
            r_item.target <= i_target_angle;
        end
    end

    spsg_servo_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (r_item),
        .o_result   (result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_servo_level   = result.level;
    assign o_current_angle = result.angle;
    assign o_pulse_running = result.running;

`ifndef SYNTHESIS
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input not stalled with both stages full");

    a_fire_sets_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed item produced no result");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall with empty input register");
`endif

endmodule
`default_nettype wire
